// ----- hdl/cau_pkg.sv -----
// Package for the complex arithmetic unit: action and status codes, field widths,
// the saturation helpers and the control bundle that travels down the pipeline.
// No dependencies.
package cau_pkg;

   localparam int DATA_W        = 16;  // width of one complex component
   localparam int FRAC_BITS_DEF = 8;   // default number of fraction bits
   localparam int PROD_W        = 32;  // magnitude of a sum of two products
   localparam int QUO_W         = 17;  // quotient bits developed by the divider
   localparam int SQ_STEPS      = 16;  // root bits developed by the square root
   localparam int SAT_W         = 34;  // width accepted by the saturation helper

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_SUB = 3'd1;
   localparam logic [2:0] ACT_MUL = 3'd2;
   localparam logic [2:0] ACT_DIV = 3'd3;
   localparam logic [2:0] ACT_CNJ = 3'd4;
   localparam logic [2:0] ACT_NEG = 3'd5;
   localparam logic [2:0] ACT_MAG = 3'd6;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   localparam logic signed [DATA_W-1:0] MAX_POS = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] MAX_NEG = 16'sh8000;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     sat;
   } sat_type;

   // Per-item control that rides along with the arithmetic lanes.
   typedef struct packed {
      logic [2:0]               action;
      logic signed [DATA_W-1:0] re;      // finished result of the short actions
      logic signed [DATA_W-1:0] im;
      logic                     sat;
      logic                     neg_re;  // quotient signs
      logic                     neg_im;
      logic                     ovf_re;  // quotient certain to overflow
      logic                     ovf_im;
      logic                     dz;      // divisor is zero
   } ctrl_type;

   function automatic sat_type sat16(input logic signed [SAT_W-1:0] v);
      sat_type r;
      if (v > SAT_W'(signed'(MAX_POS))) begin
         r.val = MAX_POS;
         r.sat = 1'b1;
      end else if (v < SAT_W'(signed'(MAX_NEG))) begin
         r.val = MAX_NEG;
         r.sat = 1'b1;
      end else begin
         r.val = v[DATA_W-1:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   // Applies the sign to a quotient magnitude and clips it to the component range.
   function automatic sat_type sat_quo(input logic [QUO_W-1:0] q, input logic neg,
                                       input logic ovf);
      sat_type r;
      if (!neg) begin
         if (ovf || q > QUO_W'(32767)) begin
            r.val = MAX_POS;
            r.sat = 1'b1;
         end else begin
            r.val = q[DATA_W-1:0];
            r.sat = 1'b0;
         end
      end else begin
         if (ovf || q > QUO_W'(32768)) begin
            r.val = MAX_NEG;
            r.sat = 1'b1;
         end else begin
            r.val = DATA_W'(-q);
            r.sat = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

// ----- hdl/cau_iter_stage.sv -----
// One pipeline stage of the iterative part: one restoring division step on both
// quotient lanes and, after stage 0, one digit of the integer square root.
// Depends on cau_pkg.
module cau_iter_stage
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int STEP      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  ctrl_type                      in_ctrl,
   input  logic [PROD_W+FRAC_BITS-1:0]   in_rem_re,
   input  logic [PROD_W+FRAC_BITS-1:0]   in_rem_im,
   input  logic [QUO_W-1:0]              in_q_re,
   input  logic [QUO_W-1:0]              in_q_im,
   input  logic [PROD_W-1:0]             in_den,
   input  logic [PROD_W-1:0]             in_sq_x,
   input  logic [PROD_W-1:0]             in_sq_res,
   output logic                          out_valid,
   output ctrl_type                      out_ctrl,
   output logic [PROD_W+FRAC_BITS-1:0]   out_rem_re,
   output logic [PROD_W+FRAC_BITS-1:0]   out_rem_im,
   output logic [QUO_W-1:0]              out_q_re,
   output logic [QUO_W-1:0]              out_q_im,
   output logic [PROD_W-1:0]             out_den,
   output logic [PROD_W-1:0]             out_sq_x,
   output logic [PROD_W-1:0]             out_sq_res
);

   localparam int NUM_W = PROD_W + FRAC_BITS;
   localparam int CMP_W = PROD_W + QUO_W + FRAC_BITS;
   localparam int K     = QUO_W - 1 - STEP;

   logic                 valid_ff;
   ctrl_type             ctrl_ff;
   logic [NUM_W-1:0]     rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [QUO_W-1:0]     q_re_ff, q_re_in, q_im_ff, q_im_in;
   logic [PROD_W-1:0]    den_ff, sq_x_ff, sq_x_in, sq_res_ff, sq_res_in;
   logic [CMP_W-1:0]     den_sh, cmp_re, cmp_im;

   always_comb begin
      den_sh    = CMP_W'(in_den) << K;
      cmp_re    = CMP_W'(in_rem_re);
      cmp_im    = CMP_W'(in_rem_im);
      rem_re_in = in_rem_re;
      rem_im_in = in_rem_im;
      q_re_in   = in_q_re;
      q_im_in   = in_q_im;
      if (cmp_re >= den_sh) begin
         rem_re_in  = NUM_W'(cmp_re - den_sh);
         q_re_in[K] = 1'b1;
      end
      if (cmp_im >= den_sh) begin
         rem_im_in  = NUM_W'(cmp_im - den_sh);
         q_im_in[K] = 1'b1;
      end
   end

   generate
      if (STEP >= QUO_W - SQ_STEPS) begin : g_sqrt
         logic [PROD_W:0] sq_bit, sq_try;
         always_comb begin
            sq_bit = (PROD_W+1)'(1) << (2 * K);
            sq_try = {1'b0, in_sq_res} + sq_bit;
            if ({1'b0, in_sq_x} >= sq_try) begin
               sq_x_in   = in_sq_x - sq_try[PROD_W-1:0];
               sq_res_in = (in_sq_res >> 1) + sq_bit[PROD_W-1:0];
            end else begin
               sq_x_in   = in_sq_x;
               sq_res_in = in_sq_res >> 1;
            end
         end
      end else begin : g_no_sqrt
         assign sq_x_in   = in_sq_x;
         assign sq_res_in = in_sq_res;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl_ff   <= in_ctrl;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         q_re_ff   <= q_re_in;
         q_im_ff   <= q_im_in;
         den_ff    <= in_den;
         sq_x_ff   <= sq_x_in;
         sq_res_ff <= sq_res_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctrl   = ctrl_ff;
   assign out_rem_re = rem_re_ff;
   assign out_rem_im = rem_im_ff;
   assign out_q_re   = q_re_ff;
   assign out_q_im   = q_im_ff;
   assign out_den    = den_ff;
   assign out_sq_x   = sq_x_ff;
   assign out_sq_res = sq_res_ff;

endmodule

// ----- hdl/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: operand products, sums, divider setup,
// the chain of iterative stages and the output register.
// Depends on cau_pkg and cau_iter_stage.
//
// The unit takes one word per cycle while the output side does not stall and
// returns exactly one result word for each, in order. Each word holds two complex
// operands in signed fixed point and an action code on req_tuser: add, subtract,
// multiply, divide, conjugate of A, negate of A or magnitude of A. The depth of
// the pipeline is set by the restoring divider, which develops one quotient bit
// per stage over 17 stages; the integer square root for the magnitude runs
// alongside it, one root bit per stage in all but the first. Products are
// truncated toward minus infinity, quotients toward zero, and every component
// saturates to the 16-bit range with status 1. A zero divisor yields a zero
// result with status 2, and the unused action code yields all zeros. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so a stall holds every word in place and drops or repeats nothing.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // a_re [15:0], a_im [31:16], b_re [47:32], b_im [63:48]
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // res_re [15:0], res_im [31:16]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int NUM_W = PROD_W + FRAC_BITS;
   localparam int CMP_W = PROD_W + QUO_W + FRAC_BITS;

   logic enable;
   logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;

   // The whole pipeline moves when the output register can take a new word.
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   assign a_re = req_tdata[15:0];
   assign a_im = req_tdata[31:16];
   assign b_re = req_tdata[47:32];
   assign b_im = req_tdata[63:48];

   // Stage 1: all eight products, plus the actions that need only an add.
   logic                     v1_ff;
   ctrl_type                 ctrl1_ff, ctrl1_in;
   logic signed [PROD_W-1:0] prr1_ff, pii1_ff, pri1_ff, pir1_ff;
   logic signed [PROD_W-1:0] paa1_ff, pai1_ff, pbr1_ff, pbi1_ff;
   sat_type                  s1_re, s1_im;

   always_comb begin
      ctrl1_in = '0;
      ctrl1_in.action = req_tuser;
      s1_re = '0;
      s1_im = '0;
      case (req_tuser)
         ACT_ADD: begin
            s1_re = sat16(SAT_W'(a_re) + SAT_W'(b_re));
            s1_im = sat16(SAT_W'(a_im) + SAT_W'(b_im));
         end
         ACT_SUB: begin
            s1_re = sat16(SAT_W'(a_re) - SAT_W'(b_re));
            s1_im = sat16(SAT_W'(a_im) - SAT_W'(b_im));
         end
         ACT_CNJ: begin
            s1_re.val = a_re;
            s1_im = sat16(-SAT_W'(a_im));
         end
         ACT_NEG: begin
            s1_re = sat16(-SAT_W'(a_re));
            s1_im = sat16(-SAT_W'(a_im));
         end
         default: begin
         end
      endcase
      ctrl1_in.re  = s1_re.val;
      ctrl1_in.im  = s1_im.val;
      ctrl1_in.sat = s1_re.sat | s1_im.sat;
   end

   // Stage 2: sums of products.
   logic                     v2_ff;
   ctrl_type                 ctrl2_ff;
   logic signed [PROD_W:0]   mre2_ff, mim2_ff, nre2_ff, nim2_ff;
   logic [PROD_W-1:0]        den2_ff, mag2_ff;

   // Stage 3: multiply results, and the divider's magnitudes, overflow and zero checks.
   logic                     v3_ff;
   ctrl_type                 ctrl3_ff, ctrl3_in;
   logic [NUM_W-1:0]         rem3_re_ff, rem3_im_ff, rem3_re_in, rem3_im_in;
   logic [PROD_W-1:0]        den3_ff, mag3_ff;
   logic [PROD_W-1:0]        abs_re, abs_im;
   logic [CMP_W-1:0]         den_lim;
   sat_type                  s3_re, s3_im;

   always_comb begin
      ctrl3_in = ctrl2_ff;
      abs_re   = nre2_ff[PROD_W] ? PROD_W'(-nre2_ff) : nre2_ff[PROD_W-1:0];
      abs_im   = nim2_ff[PROD_W] ? PROD_W'(-nim2_ff) : nim2_ff[PROD_W-1:0];
      rem3_re_in = NUM_W'(abs_re) << FRAC_BITS;
      rem3_im_in = NUM_W'(abs_im) << FRAC_BITS;
      den_lim  = CMP_W'(den2_ff) << QUO_W;
      ctrl3_in.neg_re = nre2_ff[PROD_W];
      ctrl3_in.neg_im = nim2_ff[PROD_W];
      ctrl3_in.ovf_re = CMP_W'(rem3_re_in) >= den_lim;
      ctrl3_in.ovf_im = CMP_W'(rem3_im_in) >= den_lim;
      ctrl3_in.dz     = den2_ff == '0;
      s3_re = sat16(SAT_W'(mre2_ff >>> FRAC_BITS));
      s3_im = sat16(SAT_W'(mim2_ff >>> FRAC_BITS));
      if (ctrl2_ff.action == ACT_MUL) begin
         ctrl3_in.re  = s3_re.val;
         ctrl3_in.im  = s3_im.val;
         ctrl3_in.sat = s3_re.sat | s3_im.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl1_ff <= ctrl1_in;
         prr1_ff  <= a_re * b_re;
         pii1_ff  <= a_im * b_im;
         pri1_ff  <= a_re * b_im;
         pir1_ff  <= a_im * b_re;
         paa1_ff  <= a_re * a_re;
         pai1_ff  <= a_im * a_im;
         pbr1_ff  <= b_re * b_re;
         pbi1_ff  <= b_im * b_im;

         ctrl2_ff <= ctrl1_ff;
         mre2_ff  <= (PROD_W+1)'(prr1_ff) - (PROD_W+1)'(pii1_ff);
         mim2_ff  <= (PROD_W+1)'(pri1_ff) + (PROD_W+1)'(pir1_ff);
         nre2_ff  <= (PROD_W+1)'(prr1_ff) + (PROD_W+1)'(pii1_ff);
         nim2_ff  <= (PROD_W+1)'(pir1_ff) - (PROD_W+1)'(pri1_ff);
         den2_ff  <= PROD_W'(pbr1_ff) + PROD_W'(pbi1_ff);
         mag2_ff  <= PROD_W'(paa1_ff) + PROD_W'(pai1_ff);

         ctrl3_ff   <= ctrl3_in;
         rem3_re_ff <= rem3_re_in;
         rem3_im_ff <= rem3_im_in;
         den3_ff    <= den2_ff;
         mag3_ff    <= mag2_ff;
      end
   end

   // Iterative stages: one quotient bit per stage, one root bit per stage after the first.
   logic                 it_valid [0:QUO_W];
   ctrl_type             it_ctrl  [0:QUO_W];
   logic [NUM_W-1:0]     it_rem_re [0:QUO_W];
   logic [NUM_W-1:0]     it_rem_im [0:QUO_W];
   logic [QUO_W-1:0]     it_q_re [0:QUO_W];
   logic [QUO_W-1:0]     it_q_im [0:QUO_W];
   logic [PROD_W-1:0]    it_den [0:QUO_W];
   logic [PROD_W-1:0]    it_sq_x [0:QUO_W];
   logic [PROD_W-1:0]    it_sq_res [0:QUO_W];

   assign it_valid[0]  = v3_ff;
   assign it_ctrl[0]   = ctrl3_ff;
   assign it_rem_re[0] = rem3_re_ff;
   assign it_rem_im[0] = rem3_im_ff;
   assign it_q_re[0]   = '0;
   assign it_q_im[0]   = '0;
   assign it_den[0]    = den3_ff;
   assign it_sq_x[0]   = mag3_ff;
   assign it_sq_res[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < QUO_W; gi++) begin : g_iter
         cau_iter_stage #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (gi)
         ) u_stage (
            .clock      (clock),
            .reset      (reset),
            .enable     (enable),
            .in_valid   (it_valid[gi]),
            .in_ctrl    (it_ctrl[gi]),
            .in_rem_re  (it_rem_re[gi]),
            .in_rem_im  (it_rem_im[gi]),
            .in_q_re    (it_q_re[gi]),
            .in_q_im    (it_q_im[gi]),
            .in_den     (it_den[gi]),
            .in_sq_x    (it_sq_x[gi]),
            .in_sq_res  (it_sq_res[gi]),
            .out_valid  (it_valid[gi+1]),
            .out_ctrl   (it_ctrl[gi+1]),
            .out_rem_re (it_rem_re[gi+1]),
            .out_rem_im (it_rem_im[gi+1]),
            .out_q_re   (it_q_re[gi+1]),
            .out_q_im   (it_q_im[gi+1]),
            .out_den    (it_den[gi+1]),
            .out_sq_x   (it_sq_x[gi+1]),
            .out_sq_res (it_sq_res[gi+1])
         );
      end
   endgenerate

   // Output stage: pick the result for the action and register it.
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic [1:0]               out_st_ff, out_st_in;
   ctrl_type                 fc;
   sat_type                  q_re_s, q_im_s;
   logic                     fsat;

   always_comb begin
      fc     = it_ctrl[QUO_W];
      q_re_s = sat_quo(it_q_re[QUO_W], fc.neg_re, fc.ovf_re);
      q_im_s = sat_quo(it_q_im[QUO_W], fc.neg_im, fc.ovf_im);
      out_re_in = fc.re;
      out_im_in = fc.im;
      fsat      = fc.sat;
      case (fc.action)
         ACT_DIV: begin
            if (fc.dz) begin
               out_re_in = '0;
               out_im_in = '0;
               fsat      = 1'b0;
            end else begin
               out_re_in = q_re_s.val;
               out_im_in = q_im_s.val;
               fsat      = q_re_s.sat | q_im_s.sat;
            end
         end
         ACT_MAG: begin
            out_im_in = '0;
            if (it_sq_res[QUO_W] > PROD_W'(32767)) begin
               out_re_in = MAX_POS;
               fsat      = 1'b1;
            end else begin
               out_re_in = it_sq_res[QUO_W][DATA_W-1:0];
               fsat      = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (fc.action == ACT_DIV && fc.dz) begin
         out_st_in = ST_DZ;
      end else if (fsat) begin
         out_st_in = ST_SAT;
      end else begin
         out_st_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= it_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
         out_st_ff <= out_st_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_im_ff, out_re_ff};
   assign rsp_tuser  = out_st_ff;

endmodule

// ----- hdl/cau_checker.sv -----
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg.
module cau_checker
   import cau_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A word held back at the output keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // The input side is open exactly when the output register can move.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output space");

   // A zero divisor always comes out as a zero result.
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DZ |-> rsp_tdata == '0)
      else $error("division by zero result is not zero");

   // Status never takes the unused code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_SAT || rsp_tuser == ST_DZ)
      else $error("undefined status code");

   // Nothing is presented in the cycle after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
